/* hdl/text_console_writer_macros.svh */
// Assertion macros shared by the console writer RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("console writer check failed");

// next-cycle implication, disabled while in reset
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("console writer check failed");

`endif

/* hdl/tcw_pkg.sv */
// Shared types, codes and defaults for the text console writer.
// Depends on nothing.
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int DEF_COLUMNS     = 80;
	localparam int DEF_ROWS        = 25;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [7:0]  NEWLINE_CODE = 8'd10;
	localparam logic [15:0] BLANK_CELL   = 16'h0720;

	localparam logic [2:0] CMD_NOP     = 3'd0;
	localparam logic [2:0] CMD_PUT     = 3'd1;
	localparam logic [2:0] CMD_NEWLINE = 3'd2;
	localparam logic [2:0] CMD_READ    = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_code;
		logic [7:0] color;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} in_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic        scrolled;
	} out_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] char_code;
		logic [7:0] color;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} cmd_t;

endpackage

/* hdl/tcw_fifo.sv */
// Small synchronous word queue with full/empty flags.
// Depends on nothing; word type and depth come in as parameters.
`timescale 1ns / 1ps

module tcw_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	T mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

/* hdl/tcw_front.sv */
// Front end: classifies an incoming word into a back-end command.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_front #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  tcw_pkg::in_t  item,
	output tcw_pkg::cmd_t cmd
);

	logic in_range;

	assign in_range = ({2'b0, item.read_row} < 7'(ROWS))
		&& ({2'b0, item.read_col} < 9'(COLUMNS));

	always_comb begin
		cmd.char_code = item.char_code;
		cmd.color     = item.color;
		cmd.read_row  = item.read_row;
		cmd.read_col  = item.read_col;
		unique case (item.operation)
			tcw_pkg::OP_PUT: begin
				cmd.kind = (item.char_code == tcw_pkg::NEWLINE_CODE)
					? tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_PUT;
			end
			tcw_pkg::OP_READ: begin
				cmd.kind = in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_NOP;
			end
			tcw_pkg::OP_CLEAR: begin
				cmd.kind = tcw_pkg::CMD_CLEAR;
			end
			default: begin
				cmd.kind = tcw_pkg::CMD_NOP;
			end
		endcase
	end

endmodule

/* hdl/tcw_back.sv */
// Back end: cursor, circular row map, cell memory and command execution.
// Depends on tcw_pkg and text_console_writer_macros.svh.
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module tcw_back #(
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  tcw_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output tcw_pkg::out_t res
);

	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);
	localparam int DEPTH = ROWS << CW;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	logic [1:0]      state_q, state_d;
	logic [CW-1:0]   col_q, col_d;
	logic [RW-1:0]   row_q, row_d;
	logic [RW-1:0]   top_q, top_d;
	logic [CW-1:0]   sweep_q, sweep_d;
	logic [ROWS-1:0] row_valid_q;
	logic            rd_valid_q;
	logic [15:0]     rd_data_q;
	logic [15:0]     mem [DEPTH];

	logic [RW+4:0]  rrow_ext;
	logic [CW+6:0]  rcol_ext;
	logic [RW-1:0]  log_row;
	logic [RW:0]    phys_sum;
	logic [RW-1:0]  phys;
	logic [RW+CW-1:0] rd_addr;
	logic [RW+CW-1:0] waddr;
	logic [15:0]    wdata;
	logic [15:0]    put_cell;
	logic           we;
	logic           adv_wrap;
	logic [CW-1:0]  adv_col;
	logic [RW-1:0]  adv_row;
	logic           adv_scroll;
	logic           scroll;
	logic           set_valid;
	logic           clear_all;
	logic           capture_rd;
	logic [15:0]    res_cell;
	logic [CW+6:0]  col_ext;
	logic [RW+4:0]  row_ext;

	assign rrow_ext = {RW'(0), cmd.read_row};
	assign rcol_ext = {CW'(0), cmd.read_col};
	assign log_row  = (state_q == ST_IDLE && cmd.kind == tcw_pkg::CMD_READ)
		? rrow_ext[RW-1:0] : row_q;
	assign phys_sum = {1'b0, log_row} + {1'b0, top_q};
	assign phys     = (phys_sum >= (RW+1)'(ROWS))
		? RW'(phys_sum - (RW+1)'(ROWS)) : phys_sum[RW-1:0];
	assign rd_addr  = {phys, rcol_ext[CW-1:0]};
	assign put_cell = {cmd.color, cmd.char_code};

	assign adv_wrap   = (cmd.kind == tcw_pkg::CMD_NEWLINE) || (col_q == CW'(COLUMNS - 1));
	assign adv_col    = adv_wrap ? '0 : col_q + CW'(1);
	assign adv_scroll = adv_wrap && (row_q == RW'(ROWS - 1));
	assign adv_row    = (adv_wrap && !adv_scroll) ? row_q + RW'(1) : row_q;

	always_comb begin
		state_d    = state_q;
		col_d      = col_q;
		row_d      = row_q;
		top_d      = top_q;
		sweep_d    = sweep_q;
		we         = 1'b0;
		waddr      = {phys, col_q};
		wdata      = tcw_pkg::BLANK_CELL;
		res_push   = 1'b0;
		res_cell   = '0;
		scroll     = 1'b0;
		set_valid  = 1'b0;
		clear_all  = 1'b0;
		capture_rd = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !res_full) begin
					unique case (cmd.kind)
						tcw_pkg::CMD_CLEAR: begin
							clear_all = 1'b1;
							col_d     = '0;
							row_d     = '0;
							top_d     = '0;
							res_push  = 1'b1;
						end
						tcw_pkg::CMD_NEWLINE: begin
							col_d    = adv_col;
							row_d    = adv_row;
							scroll   = adv_scroll;
							res_push = 1'b1;
						end
						tcw_pkg::CMD_PUT: begin
							if (row_valid_q[phys]) begin
								we       = 1'b1;
								wdata    = put_cell;
								col_d    = adv_col;
								row_d    = adv_row;
								scroll   = adv_scroll;
								res_push = 1'b1;
							end else begin
								sweep_d = '0;
								state_d = ST_SWEEP;
							end
						end
						tcw_pkg::CMD_READ: begin
							capture_rd = 1'b1;
							state_d    = ST_READ;
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				res_cell = rd_valid_q ? rd_data_q : tcw_pkg::BLANK_CELL;
				res_push = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_SWEEP: begin
				we    = 1'b1;
				waddr = {phys, sweep_q};
				wdata = (sweep_q == col_q) ? put_cell : tcw_pkg::BLANK_CELL;
				if (sweep_q == CW'(COLUMNS - 1)) begin
					set_valid = 1'b1;
					col_d     = adv_col;
					row_d     = adv_row;
					scroll    = adv_scroll;
					res_push  = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					sweep_d = sweep_q + CW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (scroll) begin
			top_d = (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
		end
	end

	assign cmd_pop = res_push;
	assign col_ext = {7'd0, col_d};
	assign row_ext = {5'd0, row_d};

	always_comb begin
		res.cell_value = res_cell;
		res.cursor_col = col_ext[6:0];
		res.cursor_row = row_ext[4:0];
		res.scrolled   = scroll;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[rd_addr];
		if (capture_rd) begin
			rd_valid_q <= row_valid_q[phys];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			top_q       <= '0;
			sweep_q     <= '0;
			row_valid_q <= '0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			top_q   <= top_d;
			sweep_q <= sweep_d;
			if (clear_all) begin
				row_valid_q <= '0;
			end else begin
				if (set_valid) begin
					row_valid_q[phys] <= 1'b1;
				end
				if (scroll) begin
					row_valid_q[top_q] <= 1'b0;
				end
			end
		end
	end

	`TCW_ASSERT_NOW(a_cursor_range, clk, arst_n, 1'b1, ({1'b0, col_q} < (CW+1)'(COLUMNS)) && ({1'b0, row_q} < (RW+1)'(ROWS)) && ({1'b0, top_q} < (RW+1)'(ROWS)))
	`TCW_ASSERT_NOW(a_push_room, clk, arst_n, res_push, !res_full && cmd_valid)
	`TCW_ASSERT_NEXT(a_scroll_last_row, clk, arst_n, res_push && scroll, row_q == RW'(ROWS - 1))
	`TCW_ASSERT_NEXT(a_sweep_sets_row, clk, arst_n, set_valid && !scroll, row_valid_q[$past(phys)])

endmodule

/* hdl/text_console_writer.sv */
// Timing: the back end runs a put, newline, clear, out-of-range read or spare word from its idle
// state; an in-range read also passes READ, set by the registered read port of the cell memory, and
// a put into a row not written since reset, clear or scroll first sweeps COLUMNS cells to blank it.
// One command at a time: it waits while the result queue is full, and is popped as its result is pushed.
// Reset: queues empty, cursor home, all rows marked blank by per-row flags; no clearing pass.
// Depends on tcw_pkg, tcw_fifo, tcw_front and tcw_back.
`timescale 1ns / 1ps

module text_console_writer #(
	parameter int COLUMNS     = tcw_pkg::DEF_COLUMNS,
	parameter int ROWS        = tcw_pkg::DEF_ROWS,
	parameter int QUEUE_DEPTH = tcw_pkg::DEF_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  tcw_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output tcw_pkg::out_t result
);

	tcw_pkg::cmd_t cmd_in;
	tcw_pkg::cmd_t cmd_head;
	tcw_pkg::out_t res_word;
	logic          cmd_empty;
	logic          cmd_pop;
	logic          res_full;
	logic          res_push;

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_front (
		.item(item),
		.cmd(cmd_in)
	);

	tcw_fifo #(
		.T(tcw_pkg::cmd_t),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(cmd_in),
		.full(full),
		.pop(cmd_pop),
		.rdata(cmd_head),
		.empty(cmd_empty)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(!cmd_empty),
		.cmd(cmd_head),
		.cmd_pop(cmd_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_word)
	);

	tcw_fifo #(
		.T(tcw_pkg::out_t),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_word),
		.full(res_full),
		.pop(pop),
		.rdata(result),
		.empty(empty)
	);

endmodule

/* dv/tb_top.sv */
// Self-checking bench for text_console_writer: a directed table, then random words.
// Predicts the results of random words and untyped table rows with its own copy of the screen and cursor.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module tb_top;
	import tcw_pkg::*;

	localparam int COLS          = DEF_COLUMNS;
	localparam int LINES         = DEF_ROWS;
	localparam int CELLS         = COLS * LINES;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int RANDOM_WORDS  = 1700;
	localparam int CALM_WORDS    = 150;
	localparam int HOLD_AT       = 700;
	localparam int SETTLE_CYCLES = 2 * COLS + 16;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		in_t  word;
		bit   typed;
		out_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic empty;
	logic pop;
	in_t  item;
	out_t result;

	logic [15:0] shadow_cells [CELLS];
	int          cur_col;
	int          cur_row;
	out_t        pending_status [$];
	plan_row_t   plan [$];
	int          mismatch_count;
	int          cycle_count;
	int          line_left;
	bit          calm;

	text_console_writer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void blank_shadow();
		int i;
		for (i = 0; i < CELLS; i++)
			shadow_cells[i] = BLANK_CELL;
		cur_col = 0;
		cur_row = 0;
	endfunction

	function automatic out_t console_step(in_t w);
		out_t r;
		int   i;
		r = '0;
		case (w.operation)
			OP_PUT: begin
				if (w.char_code == NEWLINE_CODE) begin
					cur_col = 0;
					cur_row++;
				end else begin
					shadow_cells[cur_row * COLS + cur_col] = {w.color, w.char_code};
					cur_col++;
				end
				if (cur_col >= COLS) begin
					cur_col = 0;
					cur_row++;
				end
				if (cur_row >= LINES) begin
					for (i = 0; i < CELLS - COLS; i++)
						shadow_cells[i] = shadow_cells[i + COLS];
					for (i = CELLS - COLS; i < CELLS; i++)
						shadow_cells[i] = BLANK_CELL;
					cur_row = LINES - 1;
					r.scrolled = 1'b1;
				end
			end
			OP_READ: begin
				if (w.read_row < LINES && w.read_col < COLS)
					r.cell_value = shadow_cells[w.read_row * COLS + w.read_col];
			end
			OP_CLEAR: begin
				blank_shadow();
			end
			default: ;
		endcase
		r.cursor_col = 7'(cur_col);
		r.cursor_row = 5'(cur_row);
		return r;
	endfunction

	function automatic void add_step(logic [1:0] op, logic [7:0] ch, logic [7:0] attr,
			logic [4:0] rr, logic [6:0] rc, bit typed, logic [15:0] cell_want,
			logic [6:0] ccol, logic [4:0] crow, logic scr);
		plan_row_t p;
		p.word  = '{operation: op, char_code: ch, color: attr, read_row: rr, read_col: rc};
		p.typed = typed;
		p.want  = '{cell_value: cell_want, cursor_col: ccol, cursor_row: crow, scrolled: scr};
		plan.push_back(p);
	endfunction

	// mostly lines of text with reads mixed in; a little noise and a rare clear
	function automatic in_t next_word();
		in_t         w;
		logic [31:0] bits;
		int          r;
		bits = $urandom;
		w = bits[$bits(in_t)-1:0];
		r = $urandom_range(0, 999);
		if (r < 20) begin
			w.operation = OP_SPARE;
		end else if (r < 50) begin
			w.operation = OP_READ;
		end else if (r < 51) begin
			w.operation = OP_CLEAR;
		end else if (r < 200) begin
			w.operation = OP_READ;
			w.read_row  = 5'($urandom_range(0, LINES - 1));
			w.read_col  = 7'($urandom_range(0, COLS - 1));
		end else begin
			w.operation = OP_PUT;
			if (line_left == 0) begin
				w.char_code = NEWLINE_CODE;
				r = $urandom_range(0, 9);
				if (r == 0)
					line_left = $urandom_range(60, 170);
				else if (r < 3)
					line_left = 0;
				else
					line_left = $urandom_range(1, 12);
			end else begin
				line_left--;
			end
		end
		return w;
	endfunction

	task automatic drive_word(in_t w, bit typed, out_t want);
		out_t predicted;
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predicted = console_step(w);
		pending_status.push_back(typed ? want : predicted);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int   stall;
		out_t want;
		stall = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_status.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t unexpected word: cell %h col %0d row %0d scr %0d",
							$realtime, result.cell_value, result.cursor_col,
							result.cursor_row, result.scrolled);
				end else begin
					want = pending_status.pop_front();
					if (result.cell_value !== want.cell_value ||
							result.cursor_col !== want.cursor_col ||
							result.cursor_row !== want.cursor_row ||
							result.scrolled !== want.scrolled) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX) begin
							$write("%0t mismatch: expected cell %h col %0d row %0d scr %0d,",
								$realtime, want.cell_value, want.cursor_col,
								want.cursor_row, want.scrolled);
							$display(" got cell %h col %0d row %0d scr %0d",
								result.cell_value, result.cursor_col,
								result.cursor_row, result.scrolled);
						end
					end
				end
			end
			if (calm) begin
				pop <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if ($urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 13) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int k;
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		calm = 1'b0;
		line_left = 0;
		mismatch_count = 0;
		cycle_count = 0;
		blank_shadow();

		add_step(OP_READ,  8'h00, 8'h00, 5'd0,  7'd0,   1, BLANK_CELL, 7'd0, 5'd0, 1'b0);
		add_step(OP_READ,  8'hff, 8'hff, 5'd24, 7'd79,  1, BLANK_CELL, 7'd0, 5'd0, 1'b0);
		add_step(OP_READ,  8'h00, 8'h00, 5'd25, 7'd0,   1, 16'h0000,   7'd0, 5'd0, 1'b0);
		add_step(OP_READ,  8'hff, 8'hff, 5'd31, 7'd127, 1, 16'h0000,   7'd0, 5'd0, 1'b0);
		add_step(OP_READ,  8'h00, 8'h00, 5'd0,  7'd80,  1, 16'h0000,   7'd0, 5'd0, 1'b0);
		add_step(OP_SPARE, 8'hff, 8'hff, 5'd31, 7'd127, 1, 16'h0000,   7'd0, 5'd0, 1'b0);
		add_step(OP_PUT,   8'h41, 8'h1f, 5'd0,  7'd0,   1, 16'h0000,   7'd1, 5'd0, 1'b0);
		add_step(OP_READ,  8'h00, 8'h00, 5'd0,  7'd0,   1, 16'h1f41,   7'd1, 5'd0, 1'b0);
		add_step(OP_PUT,   8'hff, 8'hff, 5'd31, 7'd127, 1, 16'h0000,   7'd2, 5'd0, 1'b0);
		add_step(OP_READ,  8'h00, 8'h00, 5'd0,  7'd1,   1, 16'hffff,   7'd2, 5'd0, 1'b0);
		add_step(OP_PUT,   8'h00, 8'h00, 5'd0,  7'd0,   1, 16'h0000,   7'd3, 5'd0, 1'b0);
		add_step(OP_READ,  8'h00, 8'h00, 5'd0,  7'd2,   1, 16'h0000,   7'd3, 5'd0, 1'b0);
		add_step(OP_PUT, NEWLINE_CODE, 8'haa, 5'd0, 7'd0, 1, 16'h0000, 7'd0, 5'd1, 1'b0);
		add_step(OP_READ,  8'h00, 8'h00, 5'd0,  7'd3,   1, BLANK_CELL, 7'd0, 5'd1, 1'b0);
		add_step(OP_PUT,   8'h80, 8'h55, 5'd7,  7'd33,  0, 16'h0000,   7'd0, 5'd0, 1'b0);
		add_step(OP_SPARE, 8'h00, 8'h00, 5'd0,  7'd0,   1, 16'h0000,   7'd1, 5'd1, 1'b0);
		add_step(OP_READ,  8'h00, 8'h00, 5'd1,  7'd0,   0, 16'h0000,   7'd0, 5'd0, 1'b0);
		add_step(OP_CLEAR, 8'hff, 8'hff, 5'd31, 7'd127, 1, 16'h0000,   7'd0, 5'd0, 1'b0);
		add_step(OP_READ,  8'h00, 8'h00, 5'd1,  7'd0,   1, BLANK_CELL, 7'd0, 5'd0, 1'b0);
		add_step(OP_READ,  8'h00, 8'h00, 5'd0,  7'd0,   1, BLANK_CELL, 7'd0, 5'd0, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < plan.size(); k++)
			drive_word(plan[k].word, plan[k].typed, plan[k].want);

		for (k = 0; k < RANDOM_WORDS; k++) begin
			if (k == HOLD_AT) begin
				// hold until every word has drained
				push <= 1'b0;
				do
					@(posedge clk);
				while (pending_status.size() != 0);
			end
			if (k == RANDOM_WORDS - CALM_WORDS)
				calm = 1'b1;
			drive_word(next_word(), 1'b0, '0);
		end
		push <= 1'b0;

		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
